FILE: rtl/core/ukv_pkg.sv
package ukv_pkg;

   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = $clog2(ENTRIES + 1);

   // Port field widths are fixed.
   localparam int MODE_W  = 2;
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_LOOKUP = 2'd1,
      MODE_REMOVE = 2'd2
   } mode_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic                  exec;
      logic [MODE_W-1:0]     mode;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
      logic                  commit_insert;
   } cmd_type;

   // Handed from each cell to the next one up the row.
   typedef struct packed {
      logic                  hit;
      logic                  free_seen;
      logic [VALUE_BITS-1:0] value;
   } chain_type;

   typedef struct packed {
      logic valid;
      logic match;
   } status_type;

endpackage

FILE: rtl/core/ukv_if.sv
interface ukv_req_if;
   import ukv_pkg::*;
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [KEY_W-1:0]   key;
   logic [VALUE_W-1:0] new_value;

   modport source (output valid, mode, key, new_value, input ready);
   modport sink (input valid, mode, key, new_value, output ready);
endinterface

interface ukv_rsp_if;
   import ukv_pkg::*;
   logic               valid;
   logic               ready;
   logic               success;
   logic [VALUE_W-1:0] found_value;
   logic [COUNT_W-1:0] entry_count;
   logic               table_full;

   modport source (output valid, success, found_value, entry_count, table_full,
                   input ready);
   modport sink (input valid, success, found_value, entry_count, table_full,
                 output ready);
endinterface

FILE: rtl/core/ukv_cell.sv
module ukv_cell
   import ukv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  chain_type  chain_in,
   output chain_type  chain_out,
   output status_type status
);

   logic                  valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  match;
   logic                  first_free;
   logic                  load;

   assign match      = valid_ff && (key_ff == cmd.key);
   assign first_free = !valid_ff && !chain_in.free_seen;
   assign load       = cmd.exec && cmd.commit_insert && first_free;

   // At most one cell matches, so the value passes through unchanged elsewhere.
   assign chain_out.hit       = chain_in.hit || match;
   assign chain_out.free_seen = chain_in.free_seen || !valid_ff;
   assign chain_out.value     = match ? value_ff : chain_in.value;

   assign status.valid = valid_ff;
   assign status.match = match;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (load) begin
         valid_in = 1'b1;
         key_in   = cmd.key;
         value_in = cmd.value;
      end else if (cmd.exec && (cmd.mode == MODE_REMOVE) && match) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule

FILE: rtl/core/unique_key_value_table.sv
// A request item is captured in ST_IDLE and executed in ST_EXEC, where its
// response item is registered; ST_EXEC waits while an unread response is held.
// No new item is accepted until the current one has passed the capture and
// execute steps; a waiting response stalls execution of the next item.
// Reset clears all valid bits of the cell row and the pair count at once.
module unique_key_value_table
   import ukv_pkg::*;
(
   input logic       clock,
   input logic       reset,
   ukv_req_if.sink   req_ch,
   ukv_rsp_if.source rsp_ch
);

   state_type state_ff, state_in;

   logic [MODE_W-1:0]     op_mode_ff;
   logic [KEY_BITS-1:0]   op_key_ff;
   logic [VALUE_BITS-1:0] op_value_ff;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  success_ff, success_in;
   logic [VALUE_W-1:0]    found_ff, found_in;
   logic                  full_ff, full_in;

   logic                  req_take;
   logic                  fire;
   logic                  commit_insert;
   logic                  do_remove;

   cmd_type               cmd;
   chain_type             chain [ENTRIES+1];
   status_type            status [ENTRIES];
   logic [ENTRIES-1:0]    valid_vec;
   logic [ENTRIES-1:0]    match_vec;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Controller outputs.
   always_comb begin
      req_ch.ready = 1'b0;
      fire         = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ch.ready = 1'b1;
         ST_EXEC: fire = !rsp_valid_ff || rsp_ch.ready;
         default: begin
            req_ch.ready = 1'b0;
            fire         = 1'b0;
         end
      endcase
   end

   assign req_take = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_mode_ff  <= req_ch.mode;
         op_key_ff   <= req_ch.key[KEY_BITS-1:0];
         op_value_ff <= req_ch.new_value[VALUE_BITS-1:0];
      end
   end

   // The row: hit, free and value information ripple from cell 0 upward.
   assign chain[0].hit       = 1'b0;
   assign chain[0].free_seen = 1'b0;
   assign chain[0].value     = '0;

   assign commit_insert = (op_mode_ff == MODE_INSERT) && !chain[ENTRIES].hit
                          && chain[ENTRIES].free_seen;
   assign do_remove     = (op_mode_ff == MODE_REMOVE) && chain[ENTRIES].hit;

   assign cmd.exec          = fire;
   assign cmd.mode          = op_mode_ff;
   assign cmd.key           = op_key_ff;
   assign cmd.value         = op_value_ff;
   assign cmd.commit_insert = commit_insert;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      ukv_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1]),
         .status    (status[i])
      );
      assign valid_vec[i] = status[i].valid;
      assign match_vec[i] = status[i].match;
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      success_in   = success_ff;
      found_in     = found_ff;
      full_in      = full_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
         success_in   = 1'b0;
         found_in     = '0;
         full_in      = 1'b0;
         if (commit_insert) begin
            count_in   = count_ff + 1'b1;
            success_in = 1'b1;
         end else if (do_remove) begin
            count_in   = count_ff - 1'b1;
            success_in = 1'b1;
         end
         if ((op_mode_ff == MODE_INSERT) && !chain[ENTRIES].hit
             && !chain[ENTRIES].free_seen) begin
            full_in = 1'b1;
         end
         if ((op_mode_ff == MODE_LOOKUP) && chain[ENTRIES].hit) begin
            success_in = 1'b1;
            found_in   = VALUE_W'(chain[ENTRIES].value);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      success_ff <= success_in;
      found_ff   <= found_in;
      full_ff    <= full_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.success     = success_ff;
   assign rsp_ch.found_value = found_ff;
   assign rsp_ch.entry_count = COUNT_W'(count_ff);
   assign rsp_ch.table_full  = full_ff;

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) == 32'($countones(valid_vec)))
      else $error("pair count differs from number of valid cells");

   a_unique_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("more than one cell holds the same key");

   a_full_not_success: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && full_ff |-> !success_ff)
      else $error("failed insert reported as success");

   a_take_then_exec: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_EXEC))
      else $error("accepted item not executed");

   a_insert_needs_free: assert property (@(posedge clock) disable iff (reset)
      fire && commit_insert |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not add one pair");

endmodule
